// ----- rtl/core/etsf_pkg.sv -----
// ----------------------------------------------------------------------------
// etsf_pkg
// shared types and constants of the equivalent-time sample folder
// ----------------------------------------------------------------------------
package etsf_pkg;

    localparam int ADDR_W       = 10;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int LEN_W        = ADDR_W + 1;
    localparam int SMP_W        = 16;
    localparam int STORE_W      = SMP_W + 1;
    localparam int FRAC_W       = 16;
    localparam int PHASE_W      = ADDR_W + FRAC_W;
    localparam int SPAN_W       = PHASE_W + 1;
    localparam int STEP_W       = 26;
    localparam int DIV_W        = SPAN_W;
    localparam int CNT_W        = 32;
    localparam int HYST_W       = 14;
    localparam int THR_W        = SMP_W + 2;
    localparam int DIFF_W       = SMP_W + 1;
    localparam int CFG_W        = 26;
    localparam int CFG_IDX_W    = 2;
    localparam int OP_W         = 2;

    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(STORE_DEPTH);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
    localparam logic [HYST_W-1:0]  HYST_RESET  = HYST_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_ALIGN  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_LEVEL  = 2'd2,
        CFG_HYST   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SMP_RD,
        S_SMP_WR,
        S_DIV_PH,
        S_RD_RD,
        S_RD_CHK,
        S_AL_RD,
        S_AL_CHK,
        S_IN_RD,
        S_IN_CHK,
        S_MUL,
        S_DQ,
        S_DPOS,
        S_AL_FIN,
        S_ROT1_RD,
        S_ROT1_WR,
        S_ROT2_RD,
        S_ROT2_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- rtl/core/etsf_in_if.sv -----
// ----------------------------------------------------------------------------
// etsf_in_if
// input word channel: operation, sample and read index
// ----------------------------------------------------------------------------
interface etsf_in_if
    import etsf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [SMP_W-1:0]  sample;
    logic [ADDR_W-1:0]        read_index;

    modport source (output valid, output op, output sample, output read_index, input ready);
    modport sink   (input valid, input op, input sample, input read_index, output ready);
endinterface

// ----- rtl/core/etsf_out_if.sv -----
// ----------------------------------------------------------------------------
// etsf_out_if
// result word channel: entry read, trigger flag and sample count
// ----------------------------------------------------------------------------
interface etsf_out_if
    import etsf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  entry_value;
    logic                     entry_valid;
    logic                     trigger_found;
    logic [CNT_W-1:0]         samples_taken;

    modport source (output valid, output entry_value, output entry_valid,
                    output trigger_found, output samples_taken, input ready);
    modport sink   (input valid, input entry_value, input entry_valid,
                    input trigger_found, input samples_taken, output ready);
endinterface

// ----- rtl/core/etsf_ram.sv -----
// ----------------------------------------------------------------------------
// etsf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module etsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/etsf_div.sv -----
// ----------------------------------------------------------------------------
// etsf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module etsf_div
    import etsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_BITS = $clog2(DIV_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_W-1:0]    r_quo;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_dvs;

    logic [DIV_W:0]      shifted;
    logic                fits;

    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? DIV_W'(shifted - {1'b0, r_dvs}) : shifted[DIV_W-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
endmodule

// ----- rtl/core/equivalent_time_sample_folder_core.sv -----
// ----------------------------------------------------------------------------
// equivalent_time_sample_folder_core
// folds a sample stream into one waveform period and aligns it to a trigger
// ----------------------------------------------------------------------------
// One operation word is taken at a time; the next is accepted once the
// previous one has finished, while its result may still wait on the output.
// Every operation returns exactly one result word, unless a length or step
// write cuts it short. A sample does one ram read, one read-modify-write and
// a restoring division that wraps the fold phase modulo the period span. A
// clear, and a write of length_in_use or phase_step, runs a clearing pass
// over the store, one entry a cycle; the same pass runs after reset, and no
// word is accepted during it, while configuration writes are always taken.
// An align scans the store entry by entry, searches ahead circularly for
// each candidate low point, spends two divisions on an interpolated crossing
// position, and rotates the period through a second ram unless the crossing
// sits at entry zero. All divisions go through one shared divider and all
// store accesses through the single store ram, under a single sequencer.
// ----------------------------------------------------------------------------
module equivalent_time_sample_folder_core
    import etsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    etsf_in_if.sink              i_in,
    etsf_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // sequencer state and its next value
    t_state r_state, n_state;

    // configuration
    logic [LEN_W-1:0]         r_len, n_len;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [SMP_W-1:0]  r_level, n_level;
    logic [HYST_W-1:0]        r_hyst, n_hyst;

    // folding state
    logic [PHASE_W-1:0]       r_phase, n_phase;
    logic [CNT_W-1:0]         r_count, n_count;

    // clearing pass
    logic [ADDR_W-1:0]        r_clr_addr, n_clr_addr;
    logic                     r_clr_reply, n_clr_reply;

    // working registers
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic signed [SMP_W-1:0]  r_sample, n_sample;
    logic [LEN_W-1:0]         r_i, n_i;
    logic [LEN_W-1:0]         r_j, n_j;
    logic [ADDR_W-1:0]        r_k, n_k;
    logic [ADDR_W-1:0]        r_last, n_last;
    logic                     r_low_seen, n_low_seen;
    logic signed [SMP_W-1:0]  r_vlow, n_vlow;
    logic signed [DIFF_W-1:0] r_diff, n_diff;
    logic signed [DIFF_W-1:0] r_den, n_den;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [LEN_W-1:0]         r_rot_i, n_rot_i;
    logic [ADDR_W-1:0]        r_rot_src, n_rot_src;

    // pending result
    logic signed [SMP_W-1:0]  r_res_value, n_res_value;
    logic                     r_res_valid, n_res_valid;
    logic                     r_res_trig, n_res_trig;

    // output register
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_value;
    logic                     r_out_entry_valid;
    logic                     r_out_trig;
    logic [CNT_W-1:0]         r_out_count;
    logic                     load_out;

    // store and rotation rams
    logic                     st_we;
    logic [ADDR_W-1:0]        st_waddr;
    logic [STORE_W-1:0]       st_wdata;
    logic [ADDR_W-1:0]        st_raddr;
    logic [STORE_W-1:0]       st_rdata;
    logic                     rot_we;
    logic [ADDR_W-1:0]        rot_waddr;
    logic [STORE_W-1:0]       rot_wdata;
    logic [ADDR_W-1:0]        rot_raddr;
    logic [STORE_W-1:0]       rot_rdata;

    // shared divider
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    // derived values
    logic [LEN_W-1:0]         len_eff;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W-1:0]        phase_sum;
    logic [ADDR_W-1:0]        smp_idx;
    logic signed [SMP_W-1:0]  st_val;
    logic                     st_vld;
    logic signed [THR_W-1:0]  st_val_ext;
    logic signed [THR_W-1:0]  thr_lo;
    logic signed [THR_W-1:0]  thr_hi;
    logic signed [SMP_W:0]    avg_sum;
    logic [SMP_W+ADDR_W-1:0]  prod;
    logic [SPAN_W-1:0]        back;
    logic [SPAN_W-1:0]        phase_ext;
    logic [SPAN_W-1:0]        phase_back;
    logic [ADDR_W-1:0]        k_inc;
    logic [ADDR_W-1:0]        last_inc;
    logic [ADDR_W-1:0]        src_inc;
    logic                     in_acc;
    logic                     cfg_clears;

    // length below 2 acts as 2, above the store depth as the depth
    always_comb begin
        if (r_len < LEN_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (r_len > LEN_W'(STORE_DEPTH)) begin
            len_eff = LEN_W'(STORE_DEPTH);
        end else begin
            len_eff = r_len;
        end
    end

    assign span      = {len_eff, {FRAC_W{1'b0}}};
    assign phase_ext = {1'b0, r_phase};
    assign phase_sum = phase_ext + SPAN_W'(r_step);

    // entry under the phase, clamped into the period
    always_comb begin
        if ({1'b0, r_phase[PHASE_W-1:FRAC_W]} >= len_eff) begin
            smp_idx = ADDR_W'(len_eff - 1'b1);
        end else begin
            smp_idx = r_phase[PHASE_W-1:FRAC_W];
        end
    end

    assign st_val     = st_rdata[SMP_W-1:0];
    assign st_vld     = st_rdata[SMP_W];
    assign st_val_ext = THR_W'(st_val);
    assign thr_lo     = THR_W'(r_level) - $signed(THR_W'(r_hyst));
    assign thr_hi     = THR_W'(r_level) + $signed(THR_W'(r_hyst));

    // average of old entry and new sample, floor of the half sum
    assign avg_sum = (SMP_W+1)'(st_val) + (SMP_W+1)'(r_sample);

    // level minus low value times distance; only used when both are positive
    assign prod = r_diff[SMP_W-1:0] * r_j[ADDR_W-1:0];

    // pull the phase back by the crossing position
    assign back = {1'b0, r_pos, {FRAC_W{1'b0}}};
    assign phase_back = (phase_ext >= back) ? (phase_ext - back) : (phase_ext + span - back);

    // circular successors within the period
    assign k_inc    = ({1'b0, r_k} + 1'b1 == len_eff) ? '0 : r_k + 1'b1;
    assign last_inc = ({1'b0, r_last} + 1'b1 == len_eff) ? '0 : r_last + 1'b1;
    assign src_inc  = ({1'b0, r_rot_src} + 1'b1 == len_eff) ? '0 : r_rot_src + 1'b1;

    assign cfg_clears = i_cfg_we && ((t_cfg_idx'(i_cfg_idx) == CFG_LENGTH) ||
                                     (t_cfg_idx'(i_cfg_idx) == CFG_STEP));
    assign i_in.ready = (r_state == S_IDLE) && !cfg_clears;
    assign in_acc     = i_in.valid && i_in.ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_step      <= STEP_RESET;
            r_level     <= '0;
            r_hyst      <= HYST_RESET;
            r_phase     <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_low_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_step      <= n_step;
            r_level     <= n_level;
            r_hyst      <= n_hyst;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_low_seen  <= n_low_seen;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_sample    <= n_sample;
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_last      <= n_last;
        r_vlow      <= n_vlow;
        r_diff      <= n_diff;
        r_den       <= n_den;
        r_pos       <= n_pos;
        r_rot_i     <= n_rot_i;
        r_rot_src   <= n_rot_src;
        r_res_value <= n_res_value;
        r_res_valid <= n_res_valid;
        r_res_trig  <= n_res_trig;
        if (load_out) begin
            r_out_value       <= r_res_value;
            r_out_entry_valid <= r_res_valid;
            r_out_trig        <= r_res_trig;
            r_out_count       <= r_count;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_step      = r_step;
        n_level     = r_level;
        n_hyst      = r_hyst;
        n_phase     = r_phase;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_addr      = r_addr;
        n_sample    = r_sample;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_last      = r_last;
        n_low_seen  = r_low_seen;
        n_vlow      = r_vlow;
        n_diff      = r_diff;
        n_den       = r_den;
        n_pos       = r_pos;
        n_rot_i     = r_rot_i;
        n_rot_src   = r_rot_src;
        n_res_value = r_res_value;
        n_res_valid = r_res_valid;
        n_res_trig  = r_res_trig;
        load_out    = 1'b0;

        st_we     = 1'b0;
        st_waddr  = r_clr_addr;
        st_wdata  = '0;
        st_raddr  = '0;
        rot_we    = 1'b0;
        rot_waddr = r_rot_i[ADDR_W-1:0];
        rot_wdata = st_rdata;
        rot_raddr = r_rot_i[ADDR_W-1:0];

        div_req.start    = 1'b0;
        div_req.dividend = phase_sum;
        div_req.divisor  = span;

        case (r_state)
            S_CLEAR: begin
                // wipe valid flags across the whole store
                st_we      = 1'b1;
                st_waddr   = r_clr_addr;
                st_wdata   = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_value = '0;
                    n_res_valid = 1'b0;
                    n_res_trig  = 1'b0;
                    case (t_op'(i_in.op))
                        OP_SAMPLE: begin
                            n_addr   = smp_idx;
                            n_sample = i_in.sample;
                            n_state  = S_SMP_RD;
                        end
                        OP_ALIGN: begin
                            n_i        = '0;
                            n_low_seen = 1'b0;
                            n_state    = S_AL_RD;
                        end
                        OP_READ: begin
                            n_addr  = i_in.read_index;
                            n_state = S_RD_RD;
                        end
                        default: begin
                            n_phase     = '0;
                            n_count     = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                    endcase
                end
            end
            S_SMP_RD: begin
                st_raddr = r_addr;
                n_state  = S_SMP_WR;
            end
            S_SMP_WR: begin
                // fold the sample in and wrap the advanced phase
                st_we         = 1'b1;
                st_waddr      = r_addr;
                st_wdata      = {1'b1, st_vld ? avg_sum[SMP_W:1] : r_sample};
                div_req.start = 1'b1;
                n_count       = r_count + 1'b1;
                n_state       = S_DIV_PH;
            end
            S_DIV_PH: begin
                if (div_rsp.done) begin
                    n_phase = div_rsp.remainder[PHASE_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_RD_RD: begin
                st_raddr = r_addr;
                n_state  = S_RD_CHK;
            end
            S_RD_CHK: begin
                n_res_value = st_vld ? st_val : '0;
                n_res_valid = st_vld;
                n_state     = S_DONE;
            end
            S_AL_RD: begin
                // outer scan for a low point
                if (r_i == len_eff) begin
                    n_state = S_DONE;
                end else begin
                    st_raddr = r_i[ADDR_W-1:0];
                    n_state  = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                n_state = S_AL_RD;
                if (!st_vld) begin
                    n_i = r_i + 1'b1;
                end else if (st_val_ext <= thr_lo) begin
                    n_last     = r_i[ADDR_W-1:0];
                    n_vlow     = st_val;
                    n_low_seen = 1'b1;
                    n_i        = r_i + 1'b1;
                end else if (r_low_seen) begin
                    n_j     = LEN_W'(1);
                    n_k     = last_inc;
                    n_state = S_IN_RD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_IN_RD: begin
                // circular search ahead of the low point for a high entry
                if (r_j == len_eff) begin
                    n_low_seen = 1'b0;
                    n_i        = r_i + 1'b1;
                    n_state    = S_AL_RD;
                end else begin
                    st_raddr = r_k;
                    n_state  = S_IN_CHK;
                end
            end
            S_IN_CHK: begin
                if (st_vld && (st_val_ext >= thr_hi)) begin
                    n_den   = DIFF_W'(st_val) - DIFF_W'(r_vlow);
                    n_diff  = DIFF_W'(r_level) - DIFF_W'(r_vlow);
                    n_state = S_MUL;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_k     = k_inc;
                    n_state = S_IN_RD;
                end
            end
            S_MUL: begin
                // interpolated offset only when numerator and denominator are positive
                if ((r_diff > 0) && (r_den > 0)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(prod);
                    div_req.divisor  = DIV_W'(r_den[SMP_W-1:0]);
                    n_state          = S_DQ;
                end else begin
                    n_pos   = r_last;
                    n_state = S_AL_FIN;
                end
            end
            S_DQ: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(r_last) + div_rsp.quotient;
                    div_req.divisor  = DIV_W'(len_eff);
                    n_state          = S_DPOS;
                end
            end
            S_DPOS: begin
                if (div_rsp.done) begin
                    n_pos   = div_rsp.remainder[ADDR_W-1:0];
                    n_state = S_AL_FIN;
                end
            end
            S_AL_FIN: begin
                n_res_trig = 1'b1;
                if (r_pos == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_phase   = phase_back[PHASE_W-1:0];
                    n_rot_i   = '0;
                    n_rot_src = r_pos;
                    n_state   = S_ROT1_RD;
                end
            end
            S_ROT1_RD: begin
                // copy rotated period into the scratch ram
                st_raddr = r_rot_src;
                n_state  = S_ROT1_WR;
            end
            S_ROT1_WR: begin
                rot_we    = 1'b1;
                rot_waddr = r_rot_i[ADDR_W-1:0];
                rot_wdata = st_rdata;
                n_rot_src = src_inc;
                if (r_rot_i + 1'b1 == len_eff) begin
                    n_rot_i = '0;
                    n_state = S_ROT2_RD;
                end else begin
                    n_rot_i = r_rot_i + 1'b1;
                    n_state = S_ROT1_RD;
                end
            end
            S_ROT2_RD: begin
                // copy back into the store
                rot_raddr = r_rot_i[ADDR_W-1:0];
                n_state   = S_ROT2_WR;
            end
            S_ROT2_WR: begin
                st_we    = 1'b1;
                st_waddr = r_rot_i[ADDR_W-1:0];
                st_wdata = rot_rdata;
                if (r_rot_i + 1'b1 == len_eff) begin
                    n_state = S_DONE;
                end else begin
                    n_rot_i = r_rot_i + 1'b1;
                    n_state = S_ROT2_RD;
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes, length and step restart the fold
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LENGTH: begin
                    n_len = i_cfg_data[LEN_W-1:0];
                end
                CFG_STEP: begin
                    n_step = i_cfg_data[STEP_W-1:0];
                end
                CFG_LEVEL: begin
                    n_level = i_cfg_data[SMP_W-1:0];
                end
                CFG_HYST: begin
                    n_hyst = i_cfg_data[HYST_W-1:0];
                end
                default: begin
                end
            endcase
            if (cfg_clears) begin
                n_phase     = '0;
                n_count     = '0;
                n_clr_addr  = '0;
                n_clr_reply = 1'b0;
                n_state     = S_CLEAR;
            end
        end
    end

    etsf_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    etsf_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_rot (
        .i_clk   (i_clk),
        .i_we    (rot_we),
        .i_waddr (rot_waddr),
        .i_wdata (rot_wdata),
        .i_raddr (rot_raddr),
        .o_rdata (rot_rdata)
    );

    etsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.entry_value   = r_out_value;
    assign o_out.entry_valid   = r_out_entry_valid;
    assign o_out.trigger_found = r_out_trig;
    assign o_out.samples_taken = r_out_count;

    // divider is never restarted while it is still iterating
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // an accepted word always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted word did not start an operation");

    // at rest the fold phase stays inside one period span
    a_phase_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (phase_ext < span))
        else $error("fold phase outside the period span");

endmodule

// ----- bench/sample_fold_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_fold_checker
// watches the operation, result and register ports of the sample folder,
// predicts each result word and compares it with what the block returns
// ----------------------------------------------------------------------------
module sample_fold_checker
    import etsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    etsf_in_if                   in_mon,
    etsf_out_if                  out_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef struct {
        logic signed [SMP_W-1:0] value;
        logic                    valid;
        logic                    trig;
        logic [CNT_W-1:0]        count;
    } t_fold_word;

    t_fold_word              fold_words_due[$];

    logic signed [SMP_W-1:0] wave_store [STORE_DEPTH];
    logic                    wave_valid [STORE_DEPTH];
    longint                  phase_acc;
    logic [CNT_W-1:0]        fold_count;
    logic [LEN_W-1:0]        period_reg;
    logic [STEP_W-1:0]       step_reg;
    int                      level_reg;
    int                      hyst_reg;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            wave_store[i] = '0;
            wave_valid[i] = 1'b0;
        end
        phase_acc    = 0;
        fold_count   = '0;
        period_reg   = LEN_RESET;
        step_reg     = STEP_RESET;
        level_reg    = 0;
        hyst_reg     = int'(HYST_RESET);
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int period_len();
        if (period_reg < 2) return 2;
        if (period_reg > STORE_DEPTH) return STORE_DEPTH;
        return int'(period_reg);
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < STORE_DEPTH; i++) wave_valid[i] = 1'b0;
        phase_acc  = 0;
        fold_count = '0;
    endfunction

    function automatic void fold_sample(logic signed [SMP_W-1:0] smp);
        int len;
        int idx;
        int sum;
        len = period_len();
        idx = int'(phase_acc >> FRAC_W);
        if (idx >= len) idx = len - 1;
        if (wave_valid[idx]) begin
            sum = int'(wave_store[idx]) + int'(smp);
            wave_store[idx] = SMP_W'(sum >>> 1);
        end else begin
            wave_store[idx] = smp;
        end
        wave_valid[idx] = 1'b1;
        phase_acc  = (phase_acc + longint'(step_reg)) % (longint'(len) << FRAC_W);
        fold_count = fold_count + 1;
    endfunction

    function automatic logic align_to_trigger();
        logic signed [SMP_W-1:0] rot_val [STORE_DEPTH];
        logic                    rot_vld [STORE_DEPTH];
        int     len, lo, hi, last, pos, j, k, vl, den, num, off, src;
        logic   low_seen, found;
        longint span, back;
        len = period_len();
        lo = level_reg - hyst_reg;
        hi = level_reg + hyst_reg;
        last = 0;
        pos = 0;
        low_seen = 1'b0;
        found = 1'b0;
        for (int i = 0; i < len && !found; i++) begin
            if (!wave_valid[i]) continue;
            if (int'(wave_store[i]) <= lo) begin
                last = i;
                low_seen = 1'b1;
            end else if (low_seen) begin
                for (j = 1; j < len; j++) begin
                    k = last + j;
                    if (k >= len) k -= len;
                    if (wave_valid[k] && int'(wave_store[k]) >= hi) begin
                        vl  = int'(wave_store[last]);
                        den = int'(wave_store[k]) - vl;
                        num = (level_reg - vl) * j;
                        off = (den > 0 && num > 0) ? num / den : 0;
                        pos = last + off;
                        while (pos >= len) pos -= len;
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) low_seen = 1'b0;
            end
        end
        if (found && pos != 0) begin
            span = longint'(len) << FRAC_W;
            back = longint'(pos) << FRAC_W;
            phase_acc = (phase_acc >= back) ? phase_acc - back : phase_acc + span - back;
            if (phase_acc >= span) phase_acc -= span;
            src = pos;
            for (int i = 0; i < len; i++) begin
                rot_val[i] = wave_store[src];
                rot_vld[i] = wave_valid[src];
                src++;
                if (src >= len) src = 0;
            end
            for (int i = 0; i < len; i++) begin
                wave_store[i] = rot_val[i];
                wave_valid[i] = rot_vld[i];
            end
        end
        return found;
    endfunction

    always @(posedge i_clk) begin
        t_fold_word got;
        t_fold_word want;
        if (i_rst_n) begin
            // result side first: a word out now belongs to an earlier operation
            if (out_mon.valid && out_mon.ready) begin
                got.value = out_mon.entry_value;
                got.valid = out_mon.entry_valid;
                got.trig  = out_mon.trigger_found;
                got.count = out_mon.samples_taken;
                if (fold_words_due.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("result word with nothing due: value %0d valid %0b trig %0b count %0d",
                                 got.value, got.valid, got.trig, got.count);
                end else begin
                    want = fold_words_due.pop_front();
                    if (got.value !== want.value || got.valid !== want.valid ||
                        got.trig !== want.trig || got.count !== want.count) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch: expected value %0d valid %0b trig %0b count %0d, got value %0d valid %0b trig %0b count %0d",
                                     want.value, want.valid, want.trig, want.count,
                                     got.value, got.valid, got.trig, got.count);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                want.value = '0;
                want.valid = 1'b0;
                want.trig  = 1'b0;
                case (t_op'(in_mon.op))
                    OP_SAMPLE: fold_sample(in_mon.sample);
                    OP_ALIGN:  want.trig = align_to_trigger();
                    OP_READ: begin
                        if (wave_valid[in_mon.read_index]) begin
                            want.value = wave_store[in_mon.read_index];
                            want.valid = 1'b1;
                        end
                    end
                    default:   wipe_store();
                endcase
                want.count = fold_count;
                fold_words_due.push_back(want);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LENGTH: begin
                        period_reg = i_cfg_data[LEN_W-1:0];
                        wipe_store();
                    end
                    CFG_STEP: begin
                        step_reg = i_cfg_data[STEP_W-1:0];
                        wipe_store();
                    end
                    CFG_LEVEL: level_reg = int'($signed(i_cfg_data[SMP_W-1:0]));
                    default:   hyst_reg = int'(i_cfg_data[HYST_W-1:0]);
                endcase
            end
        end
        o_pending = fold_words_due.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives operation words and register writes into the sample folder, stalls
// both channels at random and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;
    import etsf_pkg::*;

    // run limit, well above the slowest legal run of this stimulus
    localparam int CYCLE_LIMIT = 6000000;
    // settle time before register writes: one clearing pass plus margin
    localparam int SETTLE_CYCLES = 1100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;
    int                   cycles;
    int                   words_sent;
    logic                 calm;

    etsf_in_if  in_ch ();
    etsf_out_if out_ch ();

    equivalent_time_sample_folder_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    sample_fold_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side backpressure, off during the calm stretch
    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    // one operation word; waits for acceptance, idles first at random
    task automatic send_word(input t_op op, input logic signed [SMP_W-1:0] smp,
                             input logic [ADDR_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < 37) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.sample     <= smp;
        in_ch.read_index <= idx;
        // ready is stable mid-cycle, the word goes in at the next edge
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
        words_sent++;
    endtask

    // hold off until every result word is back and the block has settled
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic setup(input int len, input int step, input int level, input int hyst);
        drain();
        write_reg(CFG_LEVEL, CFG_W'(level & 16'hffff));
        write_reg(CFG_HYST, CFG_W'(hyst));
        write_reg(CFG_LENGTH, CFG_W'(len));
        write_reg(CFG_STEP, CFG_W'(step));
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SMP_W-1:0] clamp16(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return SMP_W'(v);
    endfunction

    // triangle wave folded at the phase the block will put each sample on
    task automatic send_wave(input int len, input int step, input int level,
                             input int amp, input int count);
        longint x;
        int     v;
        for (int p = 0; p < count; p++) begin
            x = ((longint'(p) * step) >> FRAC_W) % len;
            if (x < len / 2) v = -amp + int'((4 * longint'(amp) * x) / len);
            else             v = 3 * amp - int'((4 * longint'(amp) * x) / len);
            if ($urandom_range(0, 9) == 0)
                send_word(OP_SAMPLE, SMP_W'($urandom), ADDR_W'($urandom));
            else
                send_word(OP_SAMPLE, clamp16(level + v), ADDR_W'($urandom));
        end
    endtask

    // one setting: rounds of a folded period, an align, reads, some noise
    task automatic run_phase(input int len, input int step, input int level,
                             input int hyst, input int amp, input int rounds,
                             input int max_samples);
        int eff;
        int cnt;
        int r;
        setup(len, step, level, hyst);
        eff = (len < 2) ? 2 : (len > STORE_DEPTH) ? STORE_DEPTH : len;
        repeat (rounds) begin
            cnt = (step == 0) ? 6 : int'((longint'(eff) << FRAC_W) / step) + 2;
            if (cnt > max_samples) cnt = max_samples;
            send_wave(eff, step, level, amp, cnt);
            send_word(OP_ALIGN, SMP_W'($urandom), ADDR_W'($urandom));
            repeat (3) send_word(OP_READ, SMP_W'($urandom),
                                 ADDR_W'($urandom_range(0, eff - 1)));
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(OP_CLEAR, SMP_W'($urandom), ADDR_W'($urandom));
            end else if (r < 20) begin
                // stray word, any operation; reads of never written entries are invalid
                send_word(t_op'($urandom_range(0, 3)), SMP_W'($urandom), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        int len;
        int step;
        int hyst;
        int phase_no;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_LENGTH;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_SAMPLE;
        in_ch.sample     = '0;
        in_ch.read_index = '0;
        out_ch.ready     = 1'b0;
        calm             = 1'b0;
        words_sent       = 0;
        phase_no         = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: four entries, one per sample, extremes and averaging
        setup(4, 65536, 0, 64);
        send_word(OP_SAMPLE, 16'sh7fff, '0);
        send_word(OP_SAMPLE, 16'sh8000, '0);
        send_word(OP_SAMPLE, 16'sh0000, '0);
        send_word(OP_SAMPLE, -16'sd1, '0);
        send_word(OP_SAMPLE, 16'sh7fff, '0);      // second pass averages
        send_word(OP_SAMPLE, 16'sh8000, '0);
        for (int i = 0; i < 4; i++) send_word(OP_READ, '0, ADDR_W'(i));
        send_word(OP_READ, '0, 10'h3ff);          // entry never written
        send_word(OP_ALIGN, '0, '0);              // crossing away from entry zero
        send_word(OP_READ, '0, '0);
        send_word(OP_ALIGN, '0, '0);              // low point now sits last, no crossing found
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_READ, '0, '0);
        send_word(OP_ALIGN, '0, '0);              // empty store, no crossing
        send_word(OP_SAMPLE, 16'sd5, '0);

        // register extremes: clamped lengths, zero and full step, edge levels
        run_phase(0, 0, -32768, 0, 1000, 2, 12);
        run_phase(1, 67108863, 32767, 16383, 1000, 2, 12);
        run_phase(2, 65536, 0, 0, 500, 2, 12);
        run_phase(2047, 131072, 0, 64, 20000, 1, 60);
        run_phase(1024, 65536, 100, 1, 30000, 1, 60);

        // random settings, mostly short periods; a stretch of them with no idling
        while (words_sent < 400) begin
            calm = (phase_no < 2);
            len  = $urandom_range(2, 40);
            step = $urandom_range(16384, 3 * 65536);
            hyst = $urandom_range(1, 3000);
            if ($urandom_range(0, 9) == 0) step = $urandom_range(0, 67108863);
            if ($urandom_range(0, 9) == 0) hyst = $urandom_range(0, 16383);
            run_phase(len, step, $urandom_range(0, 40000) - 20000, hyst,
                      hyst + $urandom_range(1, 12000), $urandom_range(1, 4), 80);
            phase_no++;
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
